// File: hdl/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types for the section address translator: opcodes, controller
// states and the controller-to-datapath command group.
// ----------------------------------------------------------------------------
`default_nettype none

package sat_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SECT_W  = 4;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned ENTRY_W = 3 * ADDR_W;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FWD  = 2'd1,
    OP_REV  = 2'd2,
    OP_NONE = 2'd3
  } sat_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } sat_state_t;

  typedef struct packed {
    logic              query_load;
    logic              entry_write;
    logic              hit_load;
    logic              out_load;
    logic [SECT_W-1:0] hit_section;
  } sat_cmd_t;

endpackage

`default_nettype wire

// File: hdl/section_address_translator.sv
// ----------------------------------------------------------------------------
// section_address_translator
// Section table lookup: RVA to file offset and file offset to RVA.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_wr_en/cfg_wr_data set the number of sections searched per query
//   (clamped to MAX_SECTIONS); write it only while the block is idle.
//   Input items (in_valid/in_stall) are loads or queries. A load writes one
//   table slot and gives no result; opcode 3 is dropped. A query walks the
//   table from slot 0, one entry per cycle through the table memory's read
//   port, and stops at the first hit; with a zero count it gives a miss
//   without a walk. in_stall stays high until the result is loaded, so the
//   next item is taken only after that.
//   Results leave through an output register (out_valid/out_stall); the
//   next item is taken while a result waits, and a finished query holds
//   until that register frees up. A stalled result holds its value.
//   Reset clears the section count and all handshake state; table entries
//   are undefined until loaded and must be loaded before being searched.
// ----------------------------------------------------------------------------
`default_nettype none

module section_address_translator #(
  parameter int unsigned MAX_SECTIONS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [sat_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_opcode,
  input  wire logic [sat_pkg::SECT_W-1:0]   in_entry_index,
  input  wire logic [sat_pkg::ADDR_W-1:0]   in_entry_virtual_base,
  input  wire logic [sat_pkg::ADDR_W-1:0]   in_entry_raw_size,
  input  wire logic [sat_pkg::ADDR_W-1:0]   in_entry_raw_offset,
  input  wire logic [sat_pkg::ADDR_W-1:0]   in_query_address,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [sat_pkg::ADDR_W-1:0]   out_translated,
  output logic                              out_found,
  output logic      [sat_pkg::SECT_W-1:0]   out_hit_section
);

  import sat_pkg::*;

  localparam int unsigned AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  sat_cmd_t        cmd;
  logic [AW-1:0]   rd_addr;
  logic            entry_match;

  sat_ctrl #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .AW           (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .entry_match (entry_match),
    .rd_addr     (rd_addr),
    .cmd         (cmd)
  );

  sat_dp #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .AW           (AW)
  ) u_dp (
    .clk                   (clk),
    .cmd                   (cmd),
    .rd_addr               (rd_addr),
    .entry_match           (entry_match),
    .in_opcode             (in_opcode),
    .in_entry_index        (in_entry_index),
    .in_entry_virtual_base (in_entry_virtual_base),
    .in_entry_raw_size     (in_entry_raw_size),
    .in_entry_raw_offset   (in_entry_raw_offset),
    .in_query_address      (in_query_address),
    .out_translated        (out_translated),
    .out_found             (out_found),
    .out_hit_section       (out_hit_section)
  );

endmodule

`default_nettype wire

// File: hdl/sat_ram.sv
// ----------------------------------------------------------------------------
// sat_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: hdl/sat_ctrl.sv
// ----------------------------------------------------------------------------
// sat_ctrl
// Controller: handshakes, section count register, table walk sequencing
// and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_ctrl #(
  parameter int unsigned MAX_SECTIONS = 16,
  parameter int unsigned AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [sat_pkg::COUNT_W-1:0]   cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_opcode,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  input  wire logic                          entry_match,
  output logic      [AW-1:0]                 rd_addr,
  output sat_pkg::sat_cmd_t                  cmd
);

  import sat_pkg::*;

  // wide enough for the clamped count and for the raw 5-bit register
  localparam int unsigned NW = ($clog2(MAX_SECTIONS + 1) > COUNT_W) ?
                               $clog2(MAX_SECTIONS + 1) : COUNT_W;

  sat_state_t          state_r, state_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [NW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [NW-1:0]       chk_idx_r, chk_idx_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [NW-1:0]       count_ext;
  logic [NW-1:0]       n_search;
  logic                accept;
  logic                rd_issue;
  logic                out_free;
  sat_op_t             op;

  assign count_ext = NW'(count_r);
  assign n_search  = (count_ext > NW'(MAX_SECTIONS)) ? NW'(MAX_SECTIONS) : count_ext;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign op        = sat_op_t'(in_opcode);
  assign rd_issue  = (state_r == ST_SCAN) && (rd_idx_r < n_search);
  assign rd_addr   = rd_issue ? rd_idx_r[AW-1:0] : '0;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      chk_idx_r   <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      chk_idx_r   <= chk_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = cfg_wr_en ? cfg_wr_data : count_r;
    rd_idx_nxt      = rd_idx_r;
    chk_idx_nxt     = chk_idx_r;
    chk_vld_nxt     = 1'b0;
    cmd             = '0;
    cmd.hit_section = chk_idx_r[SECT_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_LOAD: cmd.entry_write = 1'b1;
            OP_FWD, OP_REV: begin
              cmd.query_load = 1'b1;
              rd_idx_nxt     = '0;
              state_nxt      = (n_search == '0) ? ST_RESP : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // read of entry i overlaps the compare of entry i-1
        if (rd_issue) begin
          rd_idx_nxt  = rd_idx_r + NW'(1);
          chk_idx_nxt = rd_idx_r;
          chk_vld_nxt = 1'b1;
        end
        if (chk_vld_r && entry_match) begin
          cmd.hit_load = 1'b1;
          chk_vld_nxt  = 1'b0;
          state_nxt    = ST_RESP;
        end else if (chk_vld_r && (chk_idx_r == n_search - NW'(1))) begin
          chk_vld_nxt  = 1'b0;
          state_nxt    = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sat_dp.sv
// ----------------------------------------------------------------------------
// sat_dp
// Datapath: section table memory, range compare, hit capture and the
// output payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_dp #(
  parameter int unsigned MAX_SECTIONS = 16,
  parameter int unsigned AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  wire logic                         clk,
  input  wire sat_pkg::sat_cmd_t            cmd,
  input  wire logic [AW-1:0]                rd_addr,
  output logic                              entry_match,
  input  wire logic [1:0]                   in_opcode,
  input  wire logic [sat_pkg::SECT_W-1:0]   in_entry_index,
  input  wire logic [sat_pkg::ADDR_W-1:0]   in_entry_virtual_base,
  input  wire logic [sat_pkg::ADDR_W-1:0]   in_entry_raw_size,
  input  wire logic [sat_pkg::ADDR_W-1:0]   in_entry_raw_offset,
  input  wire logic [sat_pkg::ADDR_W-1:0]   in_query_address,
  output logic      [sat_pkg::ADDR_W-1:0]   out_translated,
  output logic                              out_found,
  output logic      [sat_pkg::SECT_W-1:0]   out_hit_section
);

  import sat_pkg::*;

  logic [ENTRY_W-1:0] rd_data;
  logic [31:0]        wr_idx_ext;
  logic               wr_en;

  logic [ADDR_W-1:0]  ent_vbase, ent_size, ent_offset;
  logic [ADDR_W-1:0]  lo, dst;
  logic [ADDR_W:0]    range_end;

  logic [ADDR_W-1:0]  query_r;
  logic               rev_r;
  logic               found_r;
  logic [ADDR_W-1:0]  hit_delta_r;
  logic [ADDR_W-1:0]  hit_dst_r;
  logic [SECT_W-1:0]  hit_sect_r;
  logic [ADDR_W-1:0]  out_translated_r;
  logic               out_found_r;
  logic [SECT_W-1:0]  out_hit_r;

  assign wr_idx_ext = 32'(in_entry_index);
  // slots beyond the table size are dropped
  assign wr_en      = cmd.entry_write && (wr_idx_ext < 32'(MAX_SECTIONS));

  sat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SECTIONS),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx_ext[AW-1:0]),
    .wr_data ({in_entry_virtual_base, in_entry_raw_size, in_entry_raw_offset}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign {ent_vbase, ent_size, ent_offset} = rd_data;

  // forward: window on virtual base, map to raw offset; reverse swaps them
  assign lo  = rev_r ? ent_offset : ent_vbase;
  assign dst = rev_r ? ent_vbase  : ent_offset;

  // 33-bit end so a range never wraps
  assign range_end   = {1'b0, lo} + {1'b0, ent_size};
  assign entry_match = (query_r >= lo) && ({1'b0, query_r} < range_end);

  always_ff @(posedge clk) begin
    if (cmd.query_load) begin
      query_r <= in_query_address;
      rev_r   <= (sat_op_t'(in_opcode) == OP_REV);
      found_r <= 1'b0;
    end else if (cmd.hit_load) begin
      found_r <= 1'b1;
    end
    if (cmd.hit_load) begin
      hit_delta_r <= query_r - lo;
      hit_dst_r   <= dst;
      hit_sect_r  <= cmd.hit_section;
    end
    if (cmd.out_load) begin
      out_translated_r <= found_r ? (hit_dst_r + hit_delta_r) : '0;
      out_found_r      <= found_r;
      out_hit_r        <= found_r ? hit_sect_r : '0;
    end
  end

  assign out_translated  = out_translated_r;
  assign out_found       = out_found_r;
  assign out_hit_section = out_hit_r;

endmodule

`default_nettype wire

// File: hdl/sat_checker.sv
// ----------------------------------------------------------------------------
// sat_checker
// Port-level checks for the section address translator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_opcode,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_translated,
  input wire logic        out_found,
  input wire logic [3:0]  out_hit_section
);

  import sat_pkg::*;

  // a query occupies the table walk, so the input must stall next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == OP_FWD || in_opcode == OP_REV) |=> in_stall)
    else $error("query accepted without stalling input");

  // loads complete in the accept cycle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_opcode == OP_LOAD |=> !in_stall)
    else $error("load left input stalled");

  // a miss carries zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_translated == 32'd0 && out_hit_section == 4'd0)
    else $error("miss with nonzero payload");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_translated) &&
                               $stable(out_found) && $stable(out_hit_section))
    else $error("stalled result changed");

endmodule

bind section_address_translator sat_checker u_sat_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_opcode       (in_opcode),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_translated  (out_translated),
  .out_found       (out_found),
  .out_hit_section (out_hit_section)
);

`default_nettype wire
